@@ sv/lchr_pkg.sv @@
`timescale 1ns / 1ps

package lchr_pkg;

  // Field widths
  localparam int unsigned LBA_W  = 32;
  localparam int unsigned CYL_W  = 16;
  localparam int unsigned GEO_W  = 8;
  localparam int unsigned PC_W   = 2 * GEO_W;   // records per cylinder
  localparam int unsigned CFG_IDX_W = 8;

  // Pipeline shape: quotient bits resolved per divider stage
  localparam int unsigned DIV_BITS = 4;
  localparam int unsigned DIV1_STG = LBA_W / DIV_BITS;
  localparam int unsigned DIV2_STG = PC_W / DIV_BITS;
  localparam int unsigned N_STG    = 2 + DIV1_STG + DIV2_STG;

  // Reset geometry
  localparam logic [GEO_W-1:0] HPC_RESET = GEO_W'(15);
  localparam logic [GEO_W-1:0] RPT_RESET = GEO_W'(12);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADS_PER_CYL = CFG_IDX_W'(0),
    REG_RECS_PER_TRK  = CFG_IDX_W'(1)
  } cfg_reg_e;

  // Result of one translation
  typedef struct packed {
    logic             overflow;
    logic [GEO_W-1:0] rec;
    logic [GEO_W-1:0] head;
    logic [CYL_W-1:0] cyl;
  } result_t;

endpackage

@@ sv/lchr_pipe.sv @@
`timescale 1ns / 1ps

module lchr_pipe import lchr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [LBA_W-1:0] in_lba_i,
  input  logic [GEO_W-1:0] in_hpc_i,
  input  logic [GEO_W-1:0] in_rpt_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_t          out_res_o
);

  // Per-stage working set
  typedef struct packed {
    logic [LBA_W-1:0] quo;   // dividend bits shift out, quotient bits shift in
    logic [PC_W-1:0]  rem;
    logic [PC_W-1:0]  dvs;
    logic [GEO_W-1:0] hpc;
    logic [GEO_W-1:0] rpt;
    logic [PC_W-1:0]  quo2;
    logic [GEO_W-1:0] rem2;
  } stage_t;

  stage_t stage_q [N_STG];
  stage_t stage_d [N_STG];
  logic [N_STG-1:0] valid_q;
  logic [N_STG:0]   rdy;
  logic [N_STG-1:0] up_valid;

  // Stage input: load the block number and geometry
  always_comb begin
    stage_d[0]      = '0;
    stage_d[0].quo  = in_lba_i;
    stage_d[0].hpc  = in_hpc_i;
    stage_d[0].rpt  = in_rpt_i;
  end

  // Backpressure: a stage takes a beat when empty or when it drains
  assign rdy[N_STG] = out_ready_i;
  assign up_valid[0] = in_valid_i;

  for (genvar k = 0; k < N_STG; k++) begin : g_stage
    assign rdy[k] = !valid_q[k] || rdy[k+1];
    if (k > 0) begin : g_up
      assign up_valid[k] = valid_q[k-1];
    end

    if (k == 1) begin : g_mul
      // Records per cylinder
      always_comb begin
        stage_d[k]     = stage_q[k-1];
        stage_d[k].dvs = PC_W'(stage_q[k-1].hpc) * PC_W'(stage_q[k-1].rpt);
        stage_d[k].rem = '0;
      end
    end else if (k >= 2 && k < 2 + DIV1_STG) begin : g_div1
      // Restoring division of the block number, DIV_BITS steps
      always_comb begin
        logic [PC_W:0] trial;
        logic          qb;
        stage_d[k] = stage_q[k-1];
        for (int j = 0; j < DIV_BITS; j++) begin
          trial = {stage_d[k].rem, stage_d[k].quo[LBA_W-1]};
          qb    = (trial >= {1'b0, stage_d[k].dvs});
          if (qb) begin
            trial = trial - {1'b0, stage_d[k].dvs};
          end
          stage_d[k].rem = trial[PC_W-1:0];
          stage_d[k].quo = {stage_d[k].quo[LBA_W-2:0], qb};
        end
        // Hand the remainder to the second divider
        if (k == 1 + DIV1_STG) begin
          stage_d[k].quo2 = stage_d[k].rem;
          stage_d[k].rem2 = '0;
        end
      end
    end else if (k >= 2 + DIV1_STG) begin : g_div2
      // Restoring division of the remainder by records per track
      always_comb begin
        logic [GEO_W:0] trial;
        logic           qb;
        stage_d[k] = stage_q[k-1];
        for (int j = 0; j < DIV_BITS; j++) begin
          trial = {stage_d[k].rem2, stage_d[k].quo2[PC_W-1]};
          qb    = (trial >= {1'b0, stage_d[k].rpt});
          if (qb) begin
            trial = trial - {1'b0, stage_d[k].rpt};
          end
          stage_d[k].rem2 = trial[GEO_W-1:0];
          stage_d[k].quo2 = {stage_d[k].quo2[PC_W-2:0], qb};
        end
      end
    end

    // Valid bit travels with the data
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= up_valid[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && up_valid[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  // Format the result from the last stage
  assign in_ready_o        = rdy[0];
  assign out_valid_o       = valid_q[N_STG-1];
  assign out_res_o.cyl      = stage_q[N_STG-1].quo[CYL_W-1:0];
  assign out_res_o.overflow = |stage_q[N_STG-1].quo[LBA_W-1:CYL_W];
  assign out_res_o.head     = stage_q[N_STG-1].quo2[GEO_W-1:0];
  assign out_res_o.rec      = stage_q[N_STG-1].rem2 + GEO_W'(1);

  // Divisors never zero once a beat is in flight
  a_dvs_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> (stage_q[1].dvs != '0 && stage_q[1].rpt != '0))
    else $error("zero divisor in pipeline");

  // Partial remainder stays below the divisor
  a_rem1_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1 + DIV1_STG] |-> (stage_q[1 + DIV1_STG].rem < stage_q[1 + DIV1_STG].dvs))
    else $error("cylinder remainder out of range");

  a_rem2_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[N_STG-1] |-> (stage_q[N_STG-1].rem2 < stage_q[N_STG-1].rpt))
    else $error("record remainder out of range");

  // Input stalls only when every stage holds a beat
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q))
    else $error("input stalled with a bubble in the pipeline");

endmodule

@@ sv/lba_to_cylinder_head_record.sv @@
`timescale 1ns / 1ps
// Stages from input beat to result beat: input register, multiply,
//   eight radix-16 stages for the cylinder divide, four for the head divide.
// Throughput: one beat per cycle while m_axis_tready is high; on a stall, empty stages still fill.
// Reset: clears all stage valid bits; heads per cylinder returns to 15 and
//   records per track to 12.
module lba_to_cylinder_head_record import lchr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GEO_W-1:0]     cfg_data_i,
  // Input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [LBA_W-1:0]     s_axis_tdata,   // [31:0] block_number
  // Result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // [15:0] cylinder, [23:16] head, [31:24] record
  output logic                 m_axis_tuser    // [0] cylinder_overflow
);

  logic [GEO_W-1:0] hpc_q, hpc_d;
  logic [GEO_W-1:0] rpt_q, rpt_d;
  logic [GEO_W-1:0] hpc_eff, rpt_eff;
  result_t          res;

  assign cfg_ready_o = 1'b1;

  // Decode configuration writes; unknown indexes are dropped
  always_comb begin
    hpc_d = hpc_q;
    rpt_d = rpt_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HEADS_PER_CYL: hpc_d = cfg_data_i;
        REG_RECS_PER_TRK:  rpt_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpc_q <= HPC_RESET;
      rpt_q <= RPT_RESET;
    end else begin
      hpc_q <= hpc_d;
      rpt_q <= rpt_d;
    end
  end

  // Treat zero geometry as one
  assign hpc_eff = (hpc_q == '0) ? GEO_W'(1) : hpc_q;
  assign rpt_eff = (rpt_q == '0) ? GEO_W'(1) : rpt_q;

  lchr_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_lba_i    (s_axis_tdata),
    .in_hpc_i    (hpc_eff),
    .in_rpt_i    (rpt_eff),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // Pack the result beat
  assign m_axis_tdata = {res.rec, res.head, res.cyl};
  assign m_axis_tuser = res.overflow;

endmodule
